// File: rtl/core/motion_adaptive_rate_controller_macros.svh
// Assertion macros shared by the rate controller RTL.
`ifndef MOTION_ADAPTIVE_RATE_CONTROLLER_MACROS_SVH
`define MOTION_ADAPTIVE_RATE_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, masked while reset is asserted.
`define MARC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// Clocked check that also holds through reset.
`define MARC_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);
`else
`define MARC_ASSERT(lbl, clk, rst_n, prop, msg)
`define MARC_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/core/marc_pkg.sv
// Types and constants of the motion-adaptive rate controller.
`default_nettype none
package marc_pkg;

    localparam int DVD_W = 32;          // divider dividend width
    localparam int DVS_W = 6;           // divider divisor width (window up to 63)
    localparam int CNT_W = 6;           // divider step count width
    localparam int SUM_W = 14;          // window sum: 63 * 255 < 2**14

    localparam int APB_AW = 5;

    localparam logic [2:0] REG_WINDOW_SIZE  = 3'd0;
    localparam logic [2:0] REG_STILL_OFFSET = 3'd1;
    localparam logic [2:0] REG_SENSITIVITY  = 3'd2;
    localparam logic [2:0] REG_HOLD_FRAMES  = 3'd3;
    localparam logic [2:0] REG_SKIP_LIMIT   = 3'd4;
    localparam logic [2:0] REG_STILL_QP     = 3'd5;
    localparam logic [2:0] REG_MAX_QP_AVG   = 3'd6;
    localparam logic [2:0] REG_CTRL_ENABLE  = 3'd7;

    localparam logic [15:0] SCALE_MAGIC = 16'd52429;  // x/10 == (x*SCALE_MAGIC) >> 19
    localparam int          SCALE_SHIFT = 19;
    localparam logic [7:0]  SCENE_MAX   = 8'd255;
    localparam logic [7:0]  CHANGE_STEP = 8'd16;
    localparam logic [7:0]  DROP_MAX    = 8'd16;
    localparam logic [15:0] HOLD_MIN    = 16'd20;
    localparam logic [7:0]  QP_KNEE     = 8'd64;
    localparam int          QP_SHIFT    = 6;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD_GO,
        S_MOD,
        S_WR,
        S_SUM,
        S_AVG_GO,
        S_AVG,
        S_MUL1,
        S_MUL2,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] nbits;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
    } t_div_sts;

endpackage
`default_nettype wire

// File: rtl/core/marc_div.sv
// Restoring divider, one quotient bit per cycle, left-aligned dividend.
`default_nettype none
module marc_div (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire  marc_pkg::t_div_ctl         i_ctl,
    input  wire  [marc_pkg::DVD_W-1:0]       i_dividend,
    input  wire  [marc_pkg::DVS_W-1:0]       i_divisor,
    output marc_pkg::t_div_sts               o_sts,
    output logic [marc_pkg::DVD_W-1:0]       o_quotient,
    output logic [marc_pkg::DVS_W-1:0]       o_remainder
);
    import marc_pkg::*;

    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;

    logic [DVS_W:0] trial;
    logic [DVS_W:0] trial_sub;
    logic           ge;

    always_comb begin
        trial     = {r_rem, r_dvd[DVD_W-1]};
        ge        = trial >= {1'b0, r_dvs};
        trial_sub = trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.start) begin
            r_cnt <= i_ctl.nbits;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // quotient bits shift in from the bottom as dividend bits leave the top
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_dvd <= {r_dvd[DVD_W-2:0], ge};
            r_rem <= ge ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign o_sts.busy  = (r_cnt != '0);
    assign o_quotient  = r_dvd;
    assign o_remainder = r_rem;

endmodule
`default_nettype wire

// File: rtl/core/motion_adaptive_rate_controller.sv
// Each picture runs through the 32-step slot modulo, the window write, the read sweep of the
//   effective window through the one-port window memory and the 14-step average divide.
// A new picture is taken only after the previous result has been loaded into the output register.
// A finished result waits in the output register while the next picture is taken.
// Reset (synchronous, active low) restores register defaults and clears the window
//   valid bits, so every slot reads DEFAULT_LEVEL until written; no clearing pass.
`default_nettype none
`include "motion_adaptive_rate_controller_macros.svh"
module motion_adaptive_rate_controller #(
    parameter int WINDOW_DEPTH  = 32,
    parameter int DEFAULT_LEVEL = 32,
    parameter int LOWER_MARGIN  = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // input stream
    input  wire                          i_s_tvalid,
    output logic                         o_s_tready,
    input  wire  [39:0]                  i_s_tdata,   // motion_in[7:0], frame_number[39:8]
    input  wire                          i_s_tuser,   // is_intra
    // result stream
    output logic                         o_m_tvalid,
    input  wire                          i_m_tready,
    // change_rate[0], scene_motion[8:1], raw_average[16:9], skip_frame[17],
    // qp_offset[24:18], zero[31:25]
    output logic [31:0]                  o_m_tdata,
    // configuration
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [marc_pkg::APB_AW-1:0]  paddr,
    input  wire  [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import marc_pkg::*;

    localparam int         AW      = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam logic [5:0] WIN_CAP = (WINDOW_DEPTH > 63) ? 6'd63 : 6'(WINDOW_DEPTH);
    localparam logic [7:0] DEF_LVL = 8'(DEFAULT_LEVEL);
    localparam logic [7:0] LMARGIN = 8'(LOWER_MARGIN);

    // ---------------- configuration registers ----------------
    logic [5:0]  r_window_size;
    logic [7:0]  r_still_offset;
    logic [7:0]  r_sensitivity;
    logic [15:0] r_hold_frames;
    logic [15:0] r_skip_limit;
    logic [5:0]  r_still_qp;
    logic [5:0]  r_max_qp_avg;
    logic        r_ctrl_enable;

    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size  <= 6'd32;
            r_still_offset <= 8'd0;
            r_sensitivity  <= 8'd10;
            r_hold_frames  <= 16'd30;
            r_skip_limit   <= 16'd0;
            r_still_qp     <= 6'd51;
            r_max_qp_avg   <= 6'd51;
            r_ctrl_enable  <= 1'b1;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_WINDOW_SIZE:  r_window_size  <= pwdata[5:0];
                REG_STILL_OFFSET: r_still_offset <= pwdata[7:0];
                REG_SENSITIVITY:  r_sensitivity  <= pwdata[7:0];
                REG_HOLD_FRAMES:  r_hold_frames  <= pwdata[15:0];
                REG_SKIP_LIMIT:   r_skip_limit   <= pwdata[15:0];
                REG_STILL_QP:     r_still_qp     <= pwdata[5:0];
                REG_MAX_QP_AVG:   r_max_qp_avg   <= pwdata[5:0];
                REG_CTRL_ENABLE:  r_ctrl_enable  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_WINDOW_SIZE:  prdata = {26'd0, r_window_size};
            REG_STILL_OFFSET: prdata = {24'd0, r_still_offset};
            REG_SENSITIVITY:  prdata = {24'd0, r_sensitivity};
            REG_HOLD_FRAMES:  prdata = {16'd0, r_hold_frames};
            REG_SKIP_LIMIT:   prdata = {16'd0, r_skip_limit};
            REG_STILL_QP:     prdata = {26'd0, r_still_qp};
            REG_MAX_QP_AVG:   prdata = {26'd0, r_max_qp_avg};
            REG_CTRL_ENABLE:  prdata = {31'd0, r_ctrl_enable};
            default:          prdata = '0;
        endcase
    end

    // effective window: zero acts as one, clamped to the memory depth (at most 63)
    logic [5:0] win;
    always_comb begin
        if (r_window_size == 6'd0) begin
            win = 6'd1;
        end else if (r_window_size > WIN_CAP) begin
            win = WIN_CAP;
        end else begin
            win = r_window_size;
        end
    end

    // ---------------- picture state ----------------
    t_state      r_state, n_state;
    logic [7:0]  r_motion;
    logic [31:0] r_frame;
    logic        r_intra;
    logic [7:0]  r_last;
    logic [15:0] r_hold;
    logic [15:0] r_skip_run;

    logic        s_xfer;
    assign o_s_tready = (r_state == S_IDLE);
    assign s_xfer     = i_s_tvalid && o_s_tready;

    // ---------------- shared divider ----------------
    t_div_ctl          div_ctl;
    t_div_sts          div_sts;
    logic [DVD_W-1:0]  div_dvd;
    logic [DVD_W-1:0]  div_quo;
    logic [DVS_W-1:0]  div_rem;

    marc_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (div_ctl),
        .i_dividend  (div_dvd),
        .i_divisor   (win),
        .o_sts       (div_sts),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // ---------------- window memory ----------------
    logic [7:0]              mem [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] r_valid;
    logic [7:0]              r_rd_q;
    logic                    r_rd_vbit;
    logic                    r_rd_en_q;
    logic [AW-1:0]           r_rd_addr;
    logic [5:0]              r_left;
    logic [SUM_W-1:0]        r_sum;
    logic [AW-1:0]           slot;
    logic [7:0]              cored;
    logic [7:0]              elem;
    logic                    mem_we;
    logic                    rd_en;

    assign slot  = AW'(div_rem);
    assign cored = (r_motion > r_still_offset) ? (r_motion - r_still_offset) : 8'd0;
    // slot never written since reset reads as the default level
    assign elem  = r_rd_vbit ? r_rd_q : DEF_LVL;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[slot] <= cored;
        end
        if (rd_en) begin
            r_rd_q    <= mem[r_rd_addr];
            r_rd_vbit <= r_valid[r_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_rd_en_q <= 1'b0;
        end else begin
            if (mem_we) begin
                r_valid[slot] <= 1'b1;
            end
            r_rd_en_q <= rd_en;
        end
    end

    // ---------------- scaling datapath ----------------
    logic [7:0]  r_raw;
    logic [15:0] r_prod;
    logic [31:0] r_q10;
    logic        load_out;

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_motion <= i_s_tdata[7:0];
            r_frame  <= i_s_tdata[39:8];
            r_intra  <= i_s_tuser;
        end
        // sweep reads slots 0 .. win-1; read data is registered and arrives in the cycle after the address
        if (r_state == S_WR) begin
            r_left    <= win;
            r_rd_addr <= '0;
        end else if (rd_en) begin
            r_left    <= r_left - 6'd1;
            r_rd_addr <= r_rd_addr + 1'b1;
        end
        if (r_state == S_WR) begin
            r_sum <= '0;
        end else if (r_rd_en_q) begin
            r_sum <= r_sum + {{(SUM_W-8){1'b0}}, elem};
        end
        if (r_state == S_MUL1) begin
            r_raw  <= div_quo[7:0];
            r_prod <= {8'd0, div_quo[7:0]} * {8'd0, r_sensitivity};
        end
        if (r_state == S_MUL2) begin
            r_q10 <= {16'd0, r_prod} * {16'd0, SCALE_MAGIC};
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (s_xfer) n_state = S_MOD_GO;
            S_MOD_GO: n_state = S_MOD;
            S_MOD:    if (!div_sts.busy) n_state = S_WR;
            S_WR:     n_state = S_SUM;
            S_SUM:    if (r_left == 6'd0 && !r_rd_en_q) n_state = S_AVG_GO;
            S_AVG_GO: n_state = S_AVG;
            S_AVG:    if (!div_sts.busy) n_state = S_MUL1;
            S_MUL1:   n_state = S_MUL2;
            S_MUL2:   n_state = S_DONE;
            S_DONE:   if (!o_m_tvalid || i_m_tready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        div_ctl.start = 1'b0;
        div_ctl.nbits = CNT_W'(DVD_W);
        div_dvd       = r_frame;
        mem_we        = 1'b0;
        rd_en         = 1'b0;
        load_out      = 1'b0;
        unique case (r_state)
            S_MOD_GO: div_ctl.start = 1'b1;
            S_WR:     mem_we = 1'b1;
            S_SUM:    rd_en = (r_left != 6'd0);
            S_AVG_GO: begin
                div_ctl.start = 1'b1;
                div_ctl.nbits = CNT_W'(SUM_W);
                div_dvd       = {r_sum, {(DVD_W-SUM_W){1'b0}}};
            end
            S_DONE:   load_out = !o_m_tvalid || i_m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- decision logic ----------------
    logic [12:0] scene_div;
    logic [7:0]  scene_sat;
    logic [7:0]  diff;
    logic [7:0]  lower;
    logic [15:0] hold_dec;
    logic [15:0] hold_len;
    logic        n_change;
    logic [7:0]  n_scene;
    logic [7:0]  n_last;
    logic [15:0] n_hold;
    logic        n_skip;
    logic [15:0] n_skip_run;
    logic [6:0]  ratio;
    logic [5:0]  qdiff;
    logic [12:0] qprod;
    logic [12:0] qround;
    logic [6:0]  n_qp;

    always_comb begin
        scene_div = r_q10[SCALE_SHIFT+12:SCALE_SHIFT];
        scene_sat = (scene_div > {5'd0, SCENE_MAX}) ? SCENE_MAX : scene_div[7:0];
        diff      = (r_last > scene_sat) ? (r_last - scene_sat) : (scene_sat - r_last);
        lower     = (r_last > LMARGIN) ? (r_last - LMARGIN) : 8'd0;
        hold_dec  = (r_hold == 16'd0) ? 16'd0 : (r_hold - 16'd1);
        hold_len  = (r_hold_frames > HOLD_MIN) ? r_hold_frames : HOLD_MIN;

        n_change = 1'b0;
        n_scene  = scene_sat;
        n_last   = r_last;
        n_hold   = hold_dec;
        // hold expired: look for a big step or a drop to zero from a low level
        if (hold_dec == 16'd0) begin
            n_change = (diff >= CHANGE_STEP) ||
                       (scene_sat == 8'd0 && r_last != 8'd0 && r_last <= DROP_MAX);
            if (lower > scene_sat) begin
                n_scene = lower;
            end
            if (n_change) begin
                n_last = n_scene;
                n_hold = hold_len;
            end
        end

        // still window (all slots zero) shows up as a zero sum
        n_skip     = 1'b0;
        n_skip_run = r_skip_run;
        if (r_ctrl_enable && r_skip_limit != 16'd0) begin
            if (r_sum == '0 && r_skip_run < r_skip_limit && !r_intra) begin
                n_skip     = 1'b1;
                n_skip_run = r_skip_run + 16'd1;
            end else begin
                n_skip_run = 16'd0;
            end
        end

        // QP delta = -ceil(ratio * |qdiff| / 64), i.e. floor of the negative product
        ratio  = (r_raw < QP_KNEE) ? 7'(QP_KNEE - r_raw) : 7'd0;
        qdiff  = (r_still_qp < r_max_qp_avg) ? (r_max_qp_avg - r_still_qp) : 6'd0;
        qprod  = {6'd0, ratio} * {7'd0, qdiff};
        qround = qprod + 13'd63;
        n_qp   = r_ctrl_enable ? (7'd0 - {1'b0, qround[QP_SHIFT+5:QP_SHIFT]}) : 7'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last     <= DEF_LVL;
            r_hold     <= 16'd0;
            r_skip_run <= 16'd0;
        end else if (load_out) begin
            r_last     <= n_last;
            r_hold     <= n_hold;
            r_skip_run <= n_skip_run;
        end
    end

    // ---------------- output register ----------------
    logic        r_out_valid;
    logic [31:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= {7'd0, n_qp, n_skip, r_raw, n_scene, n_change};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // ---------------- checks ----------------
    `MARC_ASSERT(a_slot_in_window, i_clk, i_rst_n, (r_state == S_WR) |-> (int'(slot) < int'(win)), "window slot beyond effective window")
    `MARC_ASSERT(a_div_start_idle, i_clk, i_rst_n, div_ctl.start |-> !div_sts.busy, "divider restarted while busy")
    `MARC_ASSERT(a_out_no_clobber, i_clk, i_rst_n, load_out |-> (!r_out_valid || i_m_tready), "pending result overwritten")
    `MARC_ASSERT(a_sweep_bound, i_clk, i_rst_n, (r_state == S_SUM) |-> (r_left <= win), "read sweep longer than window")
    `MARC_ASSERT(a_ready_quiet, i_clk, i_rst_n, o_s_tready |-> (!div_sts.busy && !r_rd_en_q), "input taken while work in flight")

endmodule
`default_nettype wire
